// ===== design/lsed_pkg.sv =====
// Shared types, constants and lookup tables for the line-sensor escape direction block.
// No dependencies. Used by lsed_vec_sum, lsed_cordic and line_sensor_escape_direction.
package lsed_pkg;

  // Mounting-angle table size and index width
  localparam int ANGLE_COUNT = 16;
  localparam int ANGLE_IDX_W = 4;

  // Vector sum width: 16 entries of magnitude below 2^30
  localparam int SUM_W = 35;
  // CORDIC datapath width: sum plus growth from the CORDIC gain
  localparam int CW = 37;
  // Angle accumulator width, units of 2^-16 degree
  localparam int ZW = 27;

  localparam int CORDIC_STEPS = 22;
  localparam int STEP_W = 5;

  localparam logic signed [ZW-1:0] DEG_180 = 27'sd11796480;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_LOAD,
    S_ROT,
    S_OUT
  } lsed_state_t;

  // Control for the vector accumulator
  typedef struct packed {
    logic clr;
    logic add;
  } sum_ctrl_t;

  // Control for the CORDIC unit
  typedef struct packed {
    logic load;
    logic rotate;
  } cordic_ctrl_t;

  // Cosine of each mounting angle, scaled by 1e9
  function automatic logic signed [SUM_W-1:0] unit_cos(input logic [ANGLE_IDX_W-1:0] idx);
    logic signed [SUM_W-1:0] v;
    case (idx)
      4'd0:    v = 35'sd882947593;
      4'd1:    v = 35'sd996194698;
      4'd2:    v = 35'sd961261696;
      4'd3:    v = 35'sd777145961;
      4'd4:    v = 35'sd484809620;
      4'd5:    v = 35'sd104528463;
      4'd6:    v = -35'sd275637356;
      4'd7:    v = -35'sd629320391;
      4'd8:    v = -35'sd874619707;
      4'd9:    v = -35'sd994521895;
      4'd10:   v = -35'sd961261696;
      4'd11:   v = -35'sd777145961;
      4'd12:   v = -35'sd484809620;
      4'd13:   v = -35'sd104528463;
      4'd14:   v = 35'sd275637356;
      4'd15:   v = 35'sd629320391;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Sine of each mounting angle, scaled by 1e9
  function automatic logic signed [SUM_W-1:0] unit_sin(input logic [ANGLE_IDX_W-1:0] idx);
    logic signed [SUM_W-1:0] v;
    case (idx)
      4'd0:    v = -35'sd469471563;
      4'd1:    v = -35'sd87155743;
      4'd2:    v = 35'sd275637356;
      4'd3:    v = 35'sd629320391;
      4'd4:    v = 35'sd874619707;
      4'd5:    v = 35'sd994521895;
      4'd6:    v = 35'sd961261696;
      4'd7:    v = 35'sd777145961;
      4'd8:    v = 35'sd484809620;
      4'd9:    v = 35'sd104528463;
      4'd10:   v = -35'sd275637356;
      4'd11:   v = -35'sd629320391;
      4'd12:   v = -35'sd874619707;
      4'd13:   v = -35'sd994521895;
      4'd14:   v = -35'sd961261696;
      4'd15:   v = -35'sd777145961;
      default: v = '0;
    endcase
    return v;
  endfunction

  // atan(2^-i) in units of 2^-16 degree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_W-1:0] step);
    logic signed [ZW-1:0] v;
    case (step)
      5'd0:    v = 27'sd2949120;
      5'd1:    v = 27'sd1740967;
      5'd2:    v = 27'sd919879;
      5'd3:    v = 27'sd466945;
      5'd4:    v = 27'sd234379;
      5'd5:    v = 27'sd117304;
      5'd6:    v = 27'sd58666;
      5'd7:    v = 27'sd29335;
      5'd8:    v = 27'sd14668;
      5'd9:    v = 27'sd7334;
      5'd10:   v = 27'sd3667;
      5'd11:   v = 27'sd1833;
      5'd12:   v = 27'sd917;
      5'd13:   v = 27'sd458;
      5'd14:   v = 27'sd229;
      5'd15:   v = 27'sd115;
      5'd16:   v = 27'sd57;
      5'd17:   v = 27'sd29;
      5'd18:   v = 27'sd14;
      5'd19:   v = 27'sd7;
      5'd20:   v = 27'sd4;
      5'd21:   v = 27'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/lsed_vec_sum.sv =====
// Vector accumulator: adds the unit vector of one mounting angle per cycle while add is set.
// Depends on lsed_pkg (tables, widths, sum_ctrl_t).
module lsed_vec_sum (
  input  logic                                 clk,
  input  lsed_pkg::sum_ctrl_t                  ctrl,
  input  logic [lsed_pkg::ANGLE_IDX_W-1:0]     idx,
  output logic signed [lsed_pkg::SUM_W-1:0]    sum_x,
  output logic signed [lsed_pkg::SUM_W-1:0]    sum_y
);
  import lsed_pkg::*;

  // One table read and one add per axis each cycle in which add is set
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      sum_x <= '0;
      sum_y <= '0;
    end else if (ctrl.add) begin
      sum_x <= sum_x + unit_cos(idx);
      sum_y <= sum_y + unit_sin(idx);
    end
  end

endmodule

// ===== design/lsed_cordic.sv =====
// CORDIC vectoring unit: one micro-rotation per cycle while rotate is set, angle clamped to +/-180 degrees.
// Depends on lsed_pkg (widths, atan table, cordic_ctrl_t).
module lsed_cordic (
  input  logic                                 clk,
  input  lsed_pkg::cordic_ctrl_t               ctrl,
  input  logic [lsed_pkg::STEP_W-1:0]          step,
  input  logic signed [lsed_pkg::SUM_W-1:0]    vec_x,
  input  logic signed [lsed_pkg::SUM_W-1:0]    vec_y,
  output logic signed [lsed_pkg::ZW-1:0]       angle
);
  import lsed_pkg::*;

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic signed [CW-1:0] x_in;
  logic signed [CW-1:0] y_in;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  // Widen the sums; shared shifters for the rotation
  always_comb begin
    x_in = CW'(vec_x);
    y_in = CW'(vec_y);
    dx   = y >>> step;
    dy   = x >>> step;
  end

  // Load folds the left half-plane onto the right; then rotate towards y = 0
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (x_in[CW-1]) begin
        x <= -x_in;
        y <= -y_in;
        z <= y_in[CW-1] ? -DEG_180 : DEG_180;
      end else begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end
    end else if (ctrl.rotate) begin
      if (!y[CW-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_q16(step);
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_q16(step);
      end
    end
  end

  // Clamp to the closed half-turn either side
  always_comb begin
    if (z > DEG_180) begin
      angle = DEG_180;
    end else if (z < -DEG_180) begin
      angle = -DEG_180;
    end else begin
      angle = z;
    end
  end

endmodule

// ===== design/line_sensor_escape_direction.sv =====
// Top level of the line-sensor escape direction block: latches, sequencer, output register.
// Depends on lsed_pkg, lsed_vec_sum and lsed_cordic.
//
// Keeps sixteen sticky line-sensor hit latches. Each input transfer optionally clears
// them, ORs in new hits, and yields one result: line_seen, and escape_angle, the whole-
// degree direction opposite the summed unit vectors of the set sensors (latch 12 follows
// latch 11, latch 13 follows latch 14). From its transfer to the next possible input
// transfer, an item passes a scan of each fitted latch through the vector adder, a load
// step, 22 iterations of the shared CORDIC rotation unit, a move into the output register
// (held while the previous result is still unaccepted) and the idle state, in which the
// next transfer is taken. The input side is ready only while the sequencer is idle; a
// finished result waits in the output register without blocking the next input transfer.
module line_sensor_escape_direction #(
  parameter int NUM_SENSORS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       hit_mask,
  input  logic              clear_latches,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              line_seen,
  output logic signed [8:0] escape_angle
);
  import lsed_pkg::*;

  localparam int SCAN   = (NUM_SENSORS < ANGLE_COUNT) ? NUM_SENSORS : ANGLE_COUNT;
  localparam int IDX_W  = (SCAN > 1) ? $clog2(SCAN) : 1;
  localparam logic signed [ZW-1:0] RND_HALF = 27'sd128;

  lsed_state_t                state;
  lsed_state_t                state_next;
  logic [15:0]                latches;
  logic [15:0]                eff;
  logic [IDX_W-1:0]           idx;
  logic [STEP_W-1:0]          step;
  logic                       vec_zero;
  sum_ctrl_t                  sum_ctrl;
  cordic_ctrl_t               cordic_ctrl;
  logic                       out_load;
  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;
  logic signed [ZW-1:0]       angle;
  logic signed [ZW-1:0]       z_rnd;
  logic signed [ZW-1:0]       z_neg;
  logic signed [ZW-1:0]       deg_mag;
  logic signed [8:0]          deg;
  logic signed [8:0]          esc;
  logic                       in_xfer;

  assign in_xfer = in_valid && in_ready;

  // Effective latches: 12 follows 11 and 13 follows 14, masked to the fitted sensors
  always_comb begin
    eff     = latches;
    eff[12] = latches[11];
    eff[13] = latches[14];
    for (int i = 0; i < 16; i++) begin
      if (i >= NUM_SENSORS) begin
        eff[i] = 1'b0;
      end
    end
  end

  // Sticky latches
  always_ff @(posedge clk) begin
    if (rst) begin
      latches <= '0;
    end else if (in_xfer) begin
      latches <= (clear_latches ? 16'h0000 : latches) | hit_mask;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    sum_ctrl     = '0;
    cordic_ctrl  = '0;
    out_load     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready     = 1'b1;
        sum_ctrl.clr = 1'b1;
        if (in_valid) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        sum_ctrl.add = eff[ANGLE_IDX_W'(idx)];
        if (idx == IDX_W'(SCAN - 1)) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cordic_ctrl.load = 1'b1;
        state_next       = S_ROT;
      end
      S_ROT: begin
        cordic_ctrl.rotate = 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Scan and iteration counters, zero-vector flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      step <= '0;
    end else begin
      if (state == S_SUM) begin
        idx <= idx + IDX_W'(1);
      end else begin
        idx <= '0;
      end
      if (state == S_ROT) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      vec_zero <= (sum_x == '0) && (sum_y == '0);
    end
  end

  lsed_vec_sum u_vec_sum (
    .clk   (clk),
    .ctrl  (sum_ctrl),
    .idx   (ANGLE_IDX_W'(idx)),
    .sum_x (sum_x),
    .sum_y (sum_y)
  );

  lsed_cordic u_cordic (
    .clk   (clk),
    .ctrl  (cordic_ctrl),
    .step  (step),
    .vec_x (sum_x),
    .vec_y (sum_y),
    .angle (angle)
  );

  // Snap to 1/256 degree, truncate to whole degrees, turn by a half revolution
  always_comb begin
    z_rnd   = (angle + RND_HALF) >>> 8;
    z_neg   = -z_rnd;
    deg_mag = z_rnd[ZW-1] ? (z_neg >>> 8) : (z_rnd >>> 8);
    if (vec_zero) begin
      deg = '0;
    end else if (z_rnd[ZW-1]) begin
      deg = -deg_mag[8:0];
    end else begin
      deg = deg_mag[8:0];
    end
    esc = deg[8] ? (deg + 9'sd180) : (deg - 9'sd180);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      line_seen    <= |eff;
      escape_angle <= (|eff) ? esc : 9'sd0;
    end
  end

endmodule

// ===== design/lsed_checker.sv =====
// Port-level checker for line_sensor_escape_direction, attached by bind.
// No package dependencies.
module lsed_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              line_seen,
  input logic signed [8:0] escape_angle
);

  // A pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_seen) && $stable(escape_angle))
    else $error("result changed while stalled");

  // No line means a zero angle
  a_no_line_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_seen |-> escape_angle == 9'sd0)
    else $error("angle non-zero without a line");

  // Busy after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_valid || !in_ready)
    else $error("input taken again too soon");

  // Angle stays within a half revolution either side
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> escape_angle >= -9'sd180 && escape_angle <= 9'sd179)
    else $error("angle out of range");

  // Nothing offered straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind line_sensor_escape_direction lsed_checker u_lsed_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .line_seen    (line_seen),
  .escape_angle (escape_angle)
);

// ===== tb/sv/lsed_escape_checker.sv =====
// Checker for the line-sensor escape direction block: watches both channels,
// predicts each result from its own copy of the hit latches and compares.
// Stand-alone; no package or RTL dependencies.
module lsed_escape_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [15:0]       hit_mask,
  input  logic              clear_latches,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              line_seen,
  input  logic signed [8:0] escape_angle,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                no_line_count
);

  localparam int     TURN_STEPS = 22;
  localparam longint ONE_DEG    = 65536;
  localparam longint HALF_TURN  = 180 * 65536;

  // Unit vectors of the mounting angles, scaled by 1e9
  localparam longint COS_E9 [0:15] = '{
    882947593, 996194698, 961261696, 777145961,
    484809620, 104528463, -275637356, -629320391,
    -874619707, -994521895, -961261696, -777145961,
    -484809620, -104528463, 275637356, 629320391
  };
  localparam longint SIN_E9 [0:15] = '{
    -469471563, -87155743, 275637356, 629320391,
    874619707, 994521895, 961261696, 777145961,
    484809620, 104528463, -275637356, -629320391,
    -874619707, -994521895, -961261696, -777145961
  };
  // atan(2^-i) in 2^-16 degree
  localparam longint ATAN_Q16 [0:21] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  typedef struct packed {
    logic              seen;
    logic signed [8:0] angle;
  } escape_result_t;

  logic [15:0]    hit_latches;
  escape_result_t expected_escapes [$];
  int             fails_q;
  int             checked_q;
  int             no_line_q;

  // Heading of (vx, vy) by CORDIC vectoring, in 2^-16 degree, clamped to +-180
  function automatic longint heading_q16(input longint vx, input longint vy);
    longint x, y, z, dx, dy;
    x = vx;
    y = vy;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < TURN_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_Q16[i];
      end
    end
    if (z > HALF_TURN) z = HALF_TURN;
    if (z < -HALF_TURN) z = -HALF_TURN;
    return z;
  endfunction

  // Escape result for a set of latch values
  function automatic escape_result_t predict_escape(input logic [15:0] latches);
    escape_result_t r;
    logic [15:0]    eff;
    longint         sx, sy, z, d;
    eff = latches;
    // latch 12 follows latch 11, latch 13 follows latch 14
    eff[12] = latches[11];
    eff[13] = latches[14];
    sx = 0;
    sy = 0;
    for (int i = 0; i < 16; i++) begin
      if (eff[i]) begin
        sx = sx + COS_E9[i];
        sy = sy + SIN_E9[i];
      end
    end
    r = '0;
    if (eff == 16'd0) return r;
    if (sx == 0 && sy == 0) begin
      z = 0;   // cancelling hits count as heading zero
    end else begin
      z = heading_q16(sx, sy);
      z = ((z + 128) >>> 8) * 256;
    end
    d = z / ONE_DEG;   // truncates toward zero
    d = (d < 0) ? d + 180 : d - 180;
    r.seen  = 1'b1;
    r.angle = d[8:0];
    return r;
  endfunction

  // Result check first, then the new transfer's expectation
  always @(posedge clk) begin
    escape_result_t exp_r;
    if (rst) begin
      hit_latches = '0;
      expected_escapes.delete();
    end else begin
      if (out_valid && out_ready) begin
        checked_q++;
        if (!line_seen) no_line_q++;
        if (expected_escapes.size() == 0) begin
          fails_q++;
          $display("%0t: unexpected result line_seen=%0b escape_angle=%0d",
                   $time, line_seen, escape_angle);
        end else begin
          exp_r = expected_escapes.pop_front();
          if (line_seen !== exp_r.seen) begin
            fails_q++;
            $display("%0t: line_seen mismatch: expected %0b, got %0b",
                     $time, exp_r.seen, line_seen);
          end
          if (escape_angle !== exp_r.angle) begin
            fails_q++;
            $display("%0t: escape_angle mismatch: expected %0d, got %0d",
                     $time, exp_r.angle, escape_angle);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (clear_latches) hit_latches = '0;
        hit_latches = hit_latches | hit_mask;
        expected_escapes.push_back(predict_escape(hit_latches));
      end
    end
    fail_count    <= fails_q;
    pending       <= expected_escapes.size();
    checked       <= checked_q;
    no_line_count <= no_line_q;
  end

  initial begin
    fails_q       = 0;
    checked_q     = 0;
    no_line_q     = 0;
    hit_latches   = '0;
    fail_count    = 0;
    pending       = 0;
    checked       = 0;
    no_line_count = 0;
  end

endmodule

// ===== tb/sv/line_sensor_escape_direction_test.sv =====
// Testbench top for line_sensor_escape_direction: directed and random hit
// patterns under several idle/stall mixes. Depends on the block and on
// lsed_escape_checker, which does all prediction and comparison.
module line_sensor_escape_direction_test;

  localparam int PHASE_ITEMS = 490;
  localparam int LONG_HOLD   = 300;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [15:0]       hit_mask;
  logic              clear_latches;
  logic              out_valid;
  logic              out_ready;
  logic              line_seen;
  logic signed [8:0] escape_angle;

  int fail_count;
  int pending;
  int checked;
  int no_line_count;
  int send_idle_pct;
  int stall_pct;
  int hold_len;
  int sent;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  line_sensor_escape_direction DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .hit_mask     (hit_mask),
    .clear_latches(clear_latches),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_seen    (line_seen),
    .escape_angle (escape_angle)
  );

  lsed_escape_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .hit_mask     (hit_mask),
    .clear_latches(clear_latches),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_seen    (line_seen),
    .escape_angle (escape_angle),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .no_line_count(no_line_count)
  );

  // Receiver: random back-pressure, with a long hold-off on request
  initial begin
    int hold_left;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one hit transfer, after an optional gap, and wait for acceptance
  task automatic offer(input logic [15:0] hits, input logic clr);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (send_idle_pct != 0 && $urandom_range(0, 15) == 0) gap = $urandom_range(1, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    hit_mask      <= hits;
    clear_latches <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Random hit pattern; clears are frequent so the sticky latches do not saturate
  task automatic pick_hits(output logic [15:0] hits, output logic clr);
    int          kind;
    logic [3:0]  pairs;
    kind = $urandom_range(0, 9);
    hits = '0;
    clr  = 1'($urandom_range(0, 1));
    case (kind)
      0, 1, 2, 3, 4: begin
        // a few sensors at once
        repeat ($urandom_range(1, 3)) hits[4'($urandom_range(0, 15))] = 1'b1;
      end
      5: begin
        // opposing pairs that sum to nothing; bits 12 and 13 are ignored
        pairs = 4'($urandom_range(0, 15));
        if (pairs[0]) hits = hits | 16'h0404;
        if (pairs[1]) hits = hits | 16'h8080;
        if (pairs[2]) hits = hits | 16'h0818;
        if (pairs[3]) hits = hits | 16'h4060;
        hits = hits | (16'($urandom_range(0, 3)) << 12);
        clr  = 1'b1;
      end
      6: begin
        hits = 16'($urandom_range(0, 16'hFFFF));
        clr  = 1'b1;
      end
      7: hits = '0;
      8: hits = (16'($urandom_range(0, 3)) << 12) | (16'h1 << $urandom_range(0, 15));
      default: hits = 16'($urandom_range(0, 16'hFFFF));
    endcase
  endtask

  initial begin
    logic [15:0] hits;
    logic        clr;
    rst           = 1'b1;
    in_valid      = 1'b0;
    hit_mask      = '0;
    clear_latches = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 0;
    sent          = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty latches, all hits, clear, each sensor alone, cancelling sets
    offer(16'h0000, 1'b0);
    offer(16'hFFFF, 1'b0);
    offer(16'h0000, 1'b1);
    for (int b = 0; b < 16; b++) offer(16'h1 << b, 1'b1);
    offer(16'h0404, 1'b1);
    offer(16'h8080, 1'b1);
    offer(16'h0818, 1'b1);
    offer(16'h4060, 1'b1);
    offer(16'h0001, 1'b0);
    offer(16'h5555, 1'b1);

    // Random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while items keep coming
        if (ph == 0 && n == 100) hold_len = LONG_HOLD;
        pick_hits(hits, clr);
        offer(hits, clr);
      end
      // sender pauses until every result has come back
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
    end

    // let any stray result show up
    repeat (80) @(posedge clk);
    $display("Sent %0d hit transfers over four idle/stall mixes and one long hold-off;",
             sent);
    $display("checked %0d escape results, %0d of them with no line.",
             checked, no_line_count);
    if (fail_count == 0) begin
      $display("line_sensor_escape_direction_test: PASS");
    end else begin
      $display("line_sensor_escape_direction_test: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30000000;
    $display("line_sensor_escape_direction_test: FAIL");
    $finish;
  end

endmodule
